// File: hdl/pbph_pkg.sv
// shared widths, register indexes, reset values and state codes for the pulse height block
`default_nettype none
package pbph_pkg;

  // fixed field widths
  localparam int BS_W   = 12;  // window start registers
  localparam int BE_W   = 13;  // window end registers
  localparam int LEN_W  = 13;  // baseline window length
  localparam int Q8_W   = 22;  // baseline and peak height results
  localparam int EVT_W  = 24;  // event number
  localparam int FRAC_W = 8;   // fraction bits of the results

  localparam logic [Q8_W-1:0] Q8_MAX = {Q8_W{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASELINE_START = 2'd0,
    CFG_BASELINE_END   = 2'd1,
    CFG_PEAK_START     = 2'd2,
    CFG_PEAK_END       = 2'd3
  } cfg_reg_t;

  localparam logic [BS_W-1:0] RST_BASELINE_START = 12'd0;
  localparam logic [BE_W-1:0] RST_BASELINE_END   = 13'd600;
  localparam logic [BS_W-1:0] RST_PEAK_START     = 12'd600;
  localparam logic [BE_W-1:0] RST_PEAK_END       = 13'd3000;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_WAIT = 3'b100
  } back_state_t;

endpackage
`default_nettype wire

// File: hdl/pbph_in_if.sv
// sample input channel
`default_nettype none
interface pbph_in_if #(
  parameter int SAMPLE_BITS = 14
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/pbph_out_if.sv
// event result channel
`default_nettype none
interface pbph_out_if;
  logic                        valid;
  logic                        ready;
  logic [pbph_pkg::EVT_W-1:0]  event_number;
  logic [pbph_pkg::Q8_W-1:0]   baseline_q8;
  logic [pbph_pkg::Q8_W-1:0]   peak_height_q8;
  logic                        window_error;

  modport source (output valid, output event_number, output baseline_q8,
                  output peak_height_q8, output window_error, input ready);
  modport sink   (input valid, input event_number, input baseline_q8,
                  input peak_height_q8, input window_error, output ready);
endinterface
`default_nettype wire

// File: hdl/pbph_cfg_if.sv
// configuration write channel
`default_nettype none
interface pbph_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pbph_pkg::CFG_IDX_W-1:0]  index;
  logic [pbph_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/pbph_queue.sv
// two-entry queue between the sample front end and the division back end
`default_nettype none
module pbph_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output      logic         push_ready,
  input  wire logic [W-1:0] push_data,
  output      logic         pop_valid,
  input  wire logic         pop_ready,
  output      logic [W-1:0] pop_data
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// File: hdl/pbph_front.sv
// front end: configuration registers, window tests, baseline sum and peak search
`default_nettype none
module pbph_front #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  pbph_in_if.sink                                    in_chan,
  pbph_cfg_if.sink                                   cfg_chan,
  output      logic                                  push_valid,
  input  wire logic                                  push_ready,
  output      logic [SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0] ev_sum,
  output      logic [SAMPLE_BITS-1:0]                ev_peak,
  output      logic                                  ev_seen,
  output      logic [pbph_pkg::LEN_W-1:0]            ev_len,
  output      logic [pbph_pkg::EVT_W-1:0]            ev_num
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int CMP_W = (IDX_W > pbph_pkg::BE_W) ? IDX_W : pbph_pkg::BE_W;

  logic [pbph_pkg::BS_W-1:0]  bs_r;
  logic [pbph_pkg::BE_W-1:0]  be_r;
  logic [pbph_pkg::BS_W-1:0]  ps_r;
  logic [pbph_pkg::BE_W-1:0]  pe_r;

  logic [IDX_W-1:0]           idx_r;
  logic [SUM_W-1:0]           sum_r;
  logic [SAMPLE_BITS-1:0]     peak_r;
  logic                       seen_r;
  logic [pbph_pkg::EVT_W-1:0] evt_r;

  logic [CMP_W-1:0]           max_c;
  logic [CMP_W-1:0]           idx_c;
  logic [CMP_W-1:0]           be_c;
  logic [CMP_W-1:0]           pe_c;
  logic [CMP_W-1:0]           len_c;
  logic                       live;
  logic                       in_base;
  logic                       in_peak;
  logic                       accept;
  logic [IDX_W-1:0]           idx_nxt;
  logic [SUM_W-1:0]           sum_nxt;
  logic [SAMPLE_BITS-1:0]     peak_nxt;
  logic                       seen_nxt;

  // configuration writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= pbph_pkg::RST_BASELINE_START;
      be_r <= pbph_pkg::RST_BASELINE_END;
      ps_r <= pbph_pkg::RST_PEAK_START;
      pe_r <= pbph_pkg::RST_PEAK_END;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (pbph_pkg::cfg_reg_t'(cfg_chan.index))
        pbph_pkg::CFG_BASELINE_START: bs_r <= cfg_chan.data[pbph_pkg::BS_W-1:0];
        pbph_pkg::CFG_BASELINE_END:   be_r <= cfg_chan.data[pbph_pkg::BE_W-1:0];
        pbph_pkg::CFG_PEAK_START:     ps_r <= cfg_chan.data[pbph_pkg::BS_W-1:0];
        pbph_pkg::CFG_PEAK_END:       pe_r <= cfg_chan.data[pbph_pkg::BE_W-1:0];
        default: ;
      endcase
    end
  end

  // window tests, ends clamped to the longest event
  assign max_c   = CMP_W'(MAX_SAMPLES);
  assign idx_c   = CMP_W'(idx_r);
  assign be_c    = (CMP_W'(be_r) > max_c) ? max_c : CMP_W'(be_r);
  assign pe_c    = (CMP_W'(pe_r) > max_c) ? max_c : CMP_W'(pe_r);
  assign live    = (idx_r < IDX_W'(MAX_SAMPLES));
  assign in_base = live && (idx_c >= CMP_W'(bs_r)) && (idx_c < be_c);
  assign in_peak = live && (idx_c >= CMP_W'(ps_r)) && (idx_c < pe_c);
  assign len_c   = (be_c > CMP_W'(bs_r)) ? (be_c - CMP_W'(bs_r)) : '0;

  assign idx_nxt  = live ? (idx_r + IDX_W'(1)) : idx_r;
  assign sum_nxt  = sum_r + (in_base ? SUM_W'(in_chan.sample) : '0);
  assign peak_nxt = (in_peak && (!seen_r || (in_chan.sample > peak_r))) ?
                    in_chan.sample : peak_r;
  assign seen_nxt = seen_r | in_peak;

  // the queue must have room before a word is taken
  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push_valid    = accept && in_chan.last;

  assign ev_sum  = sum_nxt;
  assign ev_peak = peak_nxt;
  assign ev_seen = seen_nxt;
  assign ev_len  = len_c[pbph_pkg::LEN_W-1:0];
  assign ev_num  = evt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      sum_r  <= '0;
      peak_r <= '0;
      seen_r <= 1'b0;
      evt_r  <= '0;
    end else if (accept) begin
      if (in_chan.last) begin
        idx_r  <= '0;
        sum_r  <= '0;
        peak_r <= '0;
        seen_r <= 1'b0;
        evt_r  <= evt_r + pbph_pkg::EVT_W'(1);
      end else begin
        idx_r  <= idx_nxt;
        sum_r  <= sum_nxt;
        peak_r <= peak_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/pbph_back.sv
// back end: bit-serial baseline division, peak subtraction and result register
`default_nettype none
module pbph_back #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  rec_valid,
  output      logic                                  rec_ready,
  input  wire logic [SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0] rec_sum,
  input  wire logic [SAMPLE_BITS-1:0]                rec_peak,
  input  wire logic                                  rec_seen,
  input  wire logic [pbph_pkg::LEN_W-1:0]            rec_len,
  input  wire logic [pbph_pkg::EVT_W-1:0]            rec_num,
  pbph_out_if.source                                 out_chan
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int Q_W   = SUM_W + pbph_pkg::FRAC_W;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam int BQ_W  = (Q_W > pbph_pkg::Q8_W) ? Q_W : pbph_pkg::Q8_W;
  localparam int PQ_W  = SAMPLE_BITS + pbph_pkg::FRAC_W;
  localparam int PH_W  = (PQ_W > pbph_pkg::Q8_W) ? PQ_W : pbph_pkg::Q8_W;
  localparam int LEN_W = pbph_pkg::LEN_W;

  pbph_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]           cnt_r;
  logic                       out_valid_r;
  logic [Q_W-1:0]             qd_r;
  logic [LEN_W-1:0]           rem_r;
  logic [LEN_W-1:0]           len_r;
  logic [SAMPLE_BITS-1:0]     peak_r;
  logic                       seen_r;
  logic                       err_r;
  logic [pbph_pkg::EVT_W-1:0] num_r;

  logic [pbph_pkg::EVT_W-1:0] o_num_r;
  logic [pbph_pkg::Q8_W-1:0]  o_bq_r;
  logic [pbph_pkg::Q8_W-1:0]  o_ph_r;
  logic                       o_err_r;

  logic [LEN_W:0]             shifted;
  logic                       fits;
  logic [LEN_W:0]             diff;
  logic                       start;
  logic                       load_out;
  logic                       rec_err;
  logic [BQ_W-1:0]            qx;
  logic [pbph_pkg::Q8_W-1:0]  bq;
  logic [PH_W-1:0]            pqx;
  logic [PH_W-1:0]            bqx;
  logic [PH_W-1:0]            phx;
  logic [pbph_pkg::Q8_W-1:0]  ph;

  assign rec_ready = (state_r == pbph_pkg::BK_IDLE);
  assign start     = rec_valid && rec_ready;
  assign rec_err   = (rec_len == '0);
  assign load_out  = (state_r == pbph_pkg::BK_WAIT) && (!out_valid_r || out_chan.ready);

  // one quotient bit a cycle, restoring
  assign shifted = {rem_r, qd_r[Q_W-1]};
  assign fits    = (shifted >= {1'b0, len_r});
  assign diff    = shifted - {1'b0, len_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbph_pkg::BK_IDLE: if (start) state_nxt = rec_err ? pbph_pkg::BK_WAIT : pbph_pkg::BK_DIV;
      pbph_pkg::BK_DIV:  if (cnt_r == CNT_W'(1)) state_nxt = pbph_pkg::BK_WAIT;
      pbph_pkg::BK_WAIT: if (load_out) state_nxt = pbph_pkg::BK_IDLE;
      default:           state_nxt = pbph_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbph_pkg::BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        cnt_r <= CNT_W'(Q_W);
      end else if (state_r == pbph_pkg::BK_DIV) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qd_r   <= rec_err ? '0 : {rec_sum, {pbph_pkg::FRAC_W{1'b0}}};
      rem_r  <= '0;
      len_r  <= rec_len;
      peak_r <= rec_peak;
      seen_r <= rec_seen;
      err_r  <= rec_err;
      num_r  <= rec_num;
    end else if (state_r == pbph_pkg::BK_DIV) begin
      qd_r  <= {qd_r[Q_W-2:0], fits};
      rem_r <= fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    end
  end

  // saturate the mean, then peak above it floored at zero
  assign qx  = BQ_W'(qd_r);
  assign bq  = (qx > BQ_W'(pbph_pkg::Q8_MAX)) ? pbph_pkg::Q8_MAX : qx[pbph_pkg::Q8_W-1:0];
  assign pqx = PH_W'({peak_r, {pbph_pkg::FRAC_W{1'b0}}});
  assign bqx = PH_W'(bq);
  assign phx = (seen_r && (pqx > bqx)) ? (pqx - bqx) : '0;
  assign ph  = (phx > PH_W'(pbph_pkg::Q8_MAX)) ? pbph_pkg::Q8_MAX
                                              : phx[pbph_pkg::Q8_W-1:0];

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_num_r <= num_r;
      o_bq_r  <= bq;
      o_ph_r  <= ph;
      o_err_r <= err_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.event_number   = o_num_r;
  assign out_chan.baseline_q8    = o_bq_r;
  assign out_chan.peak_height_q8 = o_ph_r;
  assign out_chan.window_error   = o_err_r;

endmodule
`default_nettype wire

// File: hdl/pulse_baseline_peak_height.sv
// top level of the baseline-subtracted pulse height analyser
//
//  channel   dir  handshake      word
//  in_chan   in   valid/ready    sample, last (one waveform sample)
//  out_chan  out  valid/ready    event_number, baseline_q8, peak_height_q8, window_error
//  cfg_chan  in   valid/ready    index, data (one register write, always ready)
//
//  samples are taken one a cycle while the queue has room; the front end sums and
//  searches in the same cycle; the back end takes an event from the queue, divides it
//  bit-serially and registers the result, and takes no new event until that result is
//  loaded into the output register; an empty window skips the divide
//  a two-word queue holds finished events; in_chan.ready drops only while it is full
//  synchronous active-low reset; no clearing pass, the block is ready the cycle after
`default_nettype none
module pulse_baseline_peak_height #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 14
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pbph_in_if.sink    in_chan,
  pbph_out_if.source out_chan,
  pbph_cfg_if.sink   cfg_chan
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  // event word: number, length, seen flag, peak, baseline sum
  localparam int REC_W = pbph_pkg::EVT_W + pbph_pkg::LEN_W + 1 + SAMPLE_BITS + SUM_W;

  // front end to queue
  logic                       push_valid;
  logic                       push_ready;
  logic [SUM_W-1:0]           ev_sum;
  logic [SAMPLE_BITS-1:0]     ev_peak;
  logic                       ev_seen;
  logic [pbph_pkg::LEN_W-1:0] ev_len;
  logic [pbph_pkg::EVT_W-1:0] ev_num;

  // queue to back end
  logic                       pop_valid;
  logic                       pop_ready;
  logic [REC_W-1:0]           push_data;
  logic [REC_W-1:0]           pop_data;
  logic [SUM_W-1:0]           rec_sum;
  logic [SAMPLE_BITS-1:0]     rec_peak;
  logic                       rec_seen;
  logic [pbph_pkg::LEN_W-1:0] rec_len;
  logic [pbph_pkg::EVT_W-1:0] rec_num;

  // window tests and accumulation, one sample a cycle while the queue has room
  pbph_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .ev_sum     (ev_sum),
    .ev_peak    (ev_peak),
    .ev_seen    (ev_seen),
    .ev_len     (ev_len),
    .ev_num     (ev_num)
  );

  assign push_data = {ev_num, ev_len, ev_seen, ev_peak, ev_sum};

  // finished events wait here while the divider is busy
  pbph_queue #(
    .W (REC_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {rec_num, rec_len, rec_seen, rec_peak, rec_sum} = pop_data;

  // mean of the baseline window and peak height above it
  pbph_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (pop_valid),
    .rec_ready (pop_ready),
    .rec_sum   (rec_sum),
    .rec_peak  (rec_peak),
    .rec_seen  (rec_seen),
    .rec_len   (rec_len),
    .rec_num   (rec_num),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire
